[rtl/core/command_gate_with_arming_lease_top_defines.svh]
`ifndef COMMAND_GATE_WITH_ARMING_LEASE_TOP_DEFINES_SVH
`define COMMAND_GATE_WITH_ARMING_LEASE_TOP_DEFINES_SVH

// same-cycle implication
`define CGAL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CGAL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/cgal_pkg.sv]
package cgal_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 32;

   // largest payload a frame may declare
   localparam logic [7:0] PAYLOAD_BYTES = 8'd64;

   localparam logic [31:0] RESP_CONST  = 32'h6D2B_79F5;
   localparam logic [31:0] NONCE_RESET = 32'hA5C3_1F27;

   localparam logic [31:0] MAGIC_RESET     = 32'd0;
   localparam logic [7:0]  VERSION_RESET   = 8'd1;
   localparam logic [31:0] LEASE_LEN_RESET = 32'd5000;
   localparam logic [31:0] MAX_INJECT_RESET = 32'd1000;

   localparam logic [7:0] LEN_POLICY  = 8'd17;
   localparam logic [7:0] LEN_ARM     = 8'd8;
   localparam logic [7:0] LEN_PATTERN = 8'd6;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BAD     = 3'd1,
      ST_REFUSED = 3'd2,
      ST_LIMIT   = 3'd3,
      ST_HWF     = 3'd4
   } status_type;

   typedef enum logic [7:0] {
      OP_INFO       = 8'd0,
      OP_STATUS     = 8'd1,
      OP_EVENT_READ = 8'd2,
      OP_CAP_START  = 8'd3,
      OP_CAP_STOP   = 8'd4,
      OP_POLICY     = 8'd5,
      OP_ARM        = 8'd6,
      OP_PATTERN    = 8'd7,
      OP_RESET      = 8'd8
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_MAGIC      = 2'd0,
      REG_PROTOCOL_VERSION = 2'd1,
      REG_LEASE_LENGTH     = 2'd2,
      REG_MAX_INJECT       = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0] frame_magic;
      logic [7:0]  protocol_version;
      logic [31:0] lease_length_ms;
      logic [31:0] max_inject_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] hdr_magic;
      logic [7:0]  hdr_version;
      logic [31:0] seq_number;
      logic [7:0]  opcode;
      logic [7:0]  payload_len;
      logic [63:0] payload_head;
      logic [31:0] now_ms;
      logic        arm_pin;
      logic        policy_accepted;
      logic        pattern_ok;
   } req_type;

   typedef struct packed {
      logic [31:0] last_seq;
      logic [31:0] nonce;
      logic        armed;
      logic [31:0] lease_deadline;
      logic        capture;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic        capture_start_pulse;
      logic        capture_stop_pulse;
      logic        policy_write;
      logic        pattern_start;
      logic [1:0]  pattern_id;
      logic [3:0]  pattern_channels;
      logic [31:0] pattern_duration_ms;
      logic        armed_now;
      logic        capture_on;
   } rsp_type;

   function automatic logic [31:0] cgal_xorshift(input logic [31:0] n);
      logic [31:0] v;
      v = n ^ RESP_CONST;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

endpackage

[rtl/core/cgal_cfg.sv]
module cgal_cfg import cgal_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FRAME_MAGIC:      cfg_in.frame_magic      = csr_wdata;
            REG_PROTOCOL_VERSION: cfg_in.protocol_version = csr_wdata[7:0];
            REG_LEASE_LENGTH:     cfg_in.lease_length_ms  = csr_wdata;
            REG_MAX_INJECT:       cfg_in.max_inject_ms    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_magic      <= MAGIC_RESET;
         cfg_ff.protocol_version <= VERSION_RESET;
         cfg_ff.lease_length_ms  <= LEASE_LEN_RESET;
         cfg_ff.max_inject_ms    <= MAX_INJECT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/cgal_eval.sv]
module cgal_eval import cgal_pkg::*; #(
   parameter logic [7:0] MAX_PAYLOAD = PAYLOAD_BYTES
) (
   input  req_type   req,
   input  state_type cur,
   input  cfg_type   cfg,
   output state_type nxt,
   output rsp_type   res
);

   logic [31:0] w0;
   logic [31:0] w1;
   logic [31:0] expect_w1;
   logic [31:0] nonce_roll;
   logic [31:0] lease_gap;
   logic        lease_live;
   logic        hdr_ok;
   logic        len_zero;
   logic [7:0]  pat;
   logic [3:0]  msk;
   logic [31:0] dur;

   assign w0         = req.payload_head[31:0];
   assign w1         = req.payload_head[63:32];
   assign expect_w1  = cgal_xorshift(w0);
   assign nonce_roll = cgal_xorshift(w1);

   // lease alive while armed and the wrapping distance to the deadline is positive
   assign lease_gap  = cur.lease_deadline - req.now_ms;
   assign lease_live = cur.armed && (lease_gap != 32'd0) && !lease_gap[31];

   assign pat = req.payload_head[7:0];
   assign msk = req.payload_head[11:8];
   assign dur = req.payload_head[47:16];

   assign len_zero = (req.payload_len == 8'd0);

   // saturated last_seq blocks every frame
   assign hdr_ok = (req.hdr_magic == cfg.frame_magic)
                && (req.hdr_version == cfg.protocol_version)
                && (req.payload_len <= MAX_PAYLOAD)
                && (cur.last_seq != '1)
                && (req.seq_number != 32'd0)
                && (req.seq_number == cur.last_seq + 32'd1);

   always_comb begin
      nxt = cur;
      res.status              = ST_BAD;
      res.capture_start_pulse = 1'b0;
      res.capture_stop_pulse  = 1'b0;
      res.policy_write        = 1'b0;
      res.pattern_start       = 1'b0;
      res.pattern_id          = 2'd0;
      res.pattern_channels    = 4'd0;
      res.pattern_duration_ms = 32'd0;

      if (hdr_ok) begin
         case (req.opcode)
            OP_INFO, OP_STATUS, OP_EVENT_READ: begin
               if (len_zero) res.status = ST_OK;
            end
            OP_CAP_START: begin
               if (len_zero) begin
                  nxt.capture = 1'b1;
                  res.capture_start_pulse = 1'b1;
                  res.status = ST_OK;
               end
            end
            OP_CAP_STOP: begin
               if (len_zero) begin
                  nxt.capture = 1'b0;
                  res.capture_stop_pulse = 1'b1;
                  res.status = ST_OK;
               end
            end
            OP_POLICY: begin
               if (req.payload_len == LEN_POLICY) begin
                  res.policy_write = 1'b1;
                  res.status = req.policy_accepted ? ST_OK : ST_LIMIT;
               end
            end
            OP_ARM: begin
               res.status = ST_REFUSED;
               if (req.payload_len == LEN_ARM && req.arm_pin &&
                   w0 == cur.nonce && w1 == expect_w1) begin
                  nxt.armed          = 1'b1;
                  nxt.lease_deadline = req.now_ms + cfg.lease_length_ms;
                  nxt.nonce          = nonce_roll;
                  res.status         = ST_OK;
               end
            end
            OP_PATTERN: begin
               if (req.payload_len != LEN_PATTERN) begin
                  res.status = ST_REFUSED;
               end else if (!lease_live) begin
                  // expired lease drops the session
                  nxt.armed  = 1'b0;
                  res.status = ST_REFUSED;
               end else if (!req.arm_pin) begin
                  res.status = ST_REFUSED;
               end else if (pat[7:2] != 6'd0 || msk == 4'd0) begin
                  res.status = ST_LIMIT;
               end else if (dur == 32'd0 || dur > cfg.max_inject_ms) begin
                  res.status = ST_LIMIT;
               end else begin
                  res.pattern_start       = 1'b1;
                  res.pattern_id          = pat[1:0];
                  res.pattern_channels    = msk;
                  res.pattern_duration_ms = dur;
                  res.status = req.pattern_ok ? ST_OK : ST_HWF;
               end
            end
            OP_RESET: begin
               if (len_zero) begin
                  nxt.armed   = 1'b0;
                  nxt.capture = 1'b0;
                  res.capture_stop_pulse = 1'b1;
                  res.status = ST_OK;
               end
            end
            default: res.status = ST_BAD;
         endcase
      end

      if (res.status != ST_BAD) nxt.last_seq = req.seq_number;

      res.armed_now  = nxt.armed;
      res.capture_on = nxt.capture;
   end

endmodule

[rtl/core/command_gate_with_arming_lease_top.sv]
// Command frame gate: each accepted req beat is one frame, answered by exactly one rsp beat
// in order. A frame is captured into an input register, checked and dispatched against the
// session state (sequence, nonce, arm lease, capture flag) once the output register is free
// or draining, and its result lands in that output register. A new frame can be taken every
// cycle while rsp_ready holds high; the rate is set by the single evaluation stage, whose
// state update must finish before the following frame is checked. The user must write the
// registers via the csr port while no frame is in flight; the block does not enforce it.
`include "command_gate_with_arming_lease_top_defines.svh"

module command_gate_with_arming_lease_top import cgal_pkg::*; #(
   parameter logic [7:0] MAX_PAYLOAD = PAYLOAD_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [31:0]            req_hdr_magic,
   input  logic [7:0]             req_hdr_version,
   input  logic [31:0]            req_seq_number,
   input  logic [7:0]             req_opcode,
   input  logic [7:0]             req_payload_len,
   input  logic [63:0]            req_payload_head,
   input  logic [31:0]            req_now_ms,
   input  logic                   req_arm_pin,
   input  logic                   req_policy_accepted,
   input  logic                   req_pattern_ok,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic                   rsp_capture_start_pulse,
   output logic                   rsp_capture_stop_pulse,
   output logic                   rsp_policy_write,
   output logic                   rsp_pattern_start,
   output logic [1:0]             rsp_pattern_id,
   output logic [3:0]             rsp_pattern_channels,
   output logic [31:0]            rsp_pattern_duration_ms,
   output logic                   rsp_armed_now,
   output logic                   rsp_capture_on,

   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg;
   req_type   req_ff;
   logic      req_valid_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   res_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      fire;
   logic      req_take;

   cgal_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cgal_eval #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_eval (
      .req (req_ff),
      .cur (state_ff),
      .cfg (cfg),
      .nxt (state_in),
      .res (res_in)
   );

   // evaluate when the output register is free or draining this cycle
   assign fire      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (fire) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.hdr_magic       <= req_hdr_magic;
         req_ff.hdr_version     <= req_hdr_version;
         req_ff.seq_number      <= req_seq_number;
         req_ff.opcode          <= req_opcode;
         req_ff.payload_len     <= req_payload_len;
         req_ff.payload_head    <= req_payload_head;
         req_ff.now_ms          <= req_now_ms;
         req_ff.arm_pin         <= req_arm_pin;
         req_ff.policy_accepted <= req_policy_accepted;
         req_ff.pattern_ok      <= req_pattern_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_seq       <= 32'd0;
         state_ff.nonce          <= NONCE_RESET;
         state_ff.armed          <= 1'b0;
         state_ff.lease_deadline <= 32'd0;
         state_ff.capture        <= 1'b0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_ff <= res_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_ff.status;
   assign rsp_capture_start_pulse = rsp_ff.capture_start_pulse;
   assign rsp_capture_stop_pulse  = rsp_ff.capture_stop_pulse;
   assign rsp_policy_write        = rsp_ff.policy_write;
   assign rsp_pattern_start       = rsp_ff.pattern_start;
   assign rsp_pattern_id          = rsp_ff.pattern_id;
   assign rsp_pattern_channels    = rsp_ff.pattern_channels;
   assign rsp_pattern_duration_ms = rsp_ff.pattern_duration_ms;
   assign rsp_armed_now           = rsp_ff.armed_now;
   assign rsp_capture_on          = rsp_ff.capture_on;

   `CGAL_ASSERT_SAME(a_start_status, clock, reset, rsp_valid && rsp_pattern_start, rsp_status == ST_OK || rsp_status == ST_HWF, "pattern start with failing status")
   `CGAL_ASSERT_SAME(a_idle_pattern_zero, clock, reset, rsp_valid && !rsp_pattern_start, rsp_pattern_id == 2'd0 && rsp_pattern_channels == 4'd0 && rsp_pattern_duration_ms == 32'd0, "pattern fields set without a run")
   `CGAL_ASSERT_NEXT(a_bad_keeps_seq, clock, reset, fire && res_in.status == ST_BAD, $stable(state_ff.last_seq), "bad frame moved the sequence")
   `CGAL_ASSERT_NEXT(a_armed_matches, clock, reset, fire, rsp_valid && rsp_armed_now == state_ff.armed && rsp_capture_on == state_ff.capture, "reported flags differ from session state")

endmodule
